// ===== rtl/core/rlle_pkg.sv =====
// ----------------------------------------------------------------------------
// rlle_pkg
// Types, constants and encode functions shared by the run-length encoder.
// ----------------------------------------------------------------------------
package rlle_pkg;

    localparam int MAX_RES   = 6;
    localparam int RES_CNT_W = 3;
    localparam int ADDR_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (ADDR_W + BYTE_W + 1 + LEN_W);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [ADDR_W-1:0] CAP_RESET = 16'hFFFF;
    localparam logic [ADDR_W-1:0] ADDR_SAT  = 16'hFFFF;

    // run state codes
    localparam logic [BYTE_W-1:0] RUN_NONE      = 8'h00;
    localparam logic [BYTE_W-1:0] LIT_ONE       = 8'h01;
    localparam logic [BYTE_W-1:0] REPEAT_START  = 8'h81;
    localparam logic [BYTE_W-1:0] REPEAT_FULL   = 8'hFF;
    localparam logic [BYTE_W-1:0] LITERAL_FULL  = 8'd127;
    localparam logic [BYTE_W-1:0] START_PENDING = 8'h80;

    // bytes_seen codes
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] held;
        logic [BYTE_W-1:0] before_held;
        logic [1:0]        seen;
        logic [BYTE_W-1:0] run;
        logic [ADDR_W-1:0] slot;
        logic [ADDR_W-1:0] nxt;
    } rlle_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              done;
        logic [LEN_W-1:0]  len;
        logic              last;
    } rlle_res_t;

    typedef rlle_res_t [MAX_RES-1:0] rlle_res_arr_t;

    typedef struct packed {
        rlle_state_t          st;
        rlle_res_arr_t        res;
        logic [RES_CNT_W-1:0] cnt;
    } rlle_work_t;

    // results of one input item handed to the output bank
    typedef struct packed {
        logic                 valid;
        logic [RES_CNT_W-1:0] cnt;
        rlle_res_arr_t        res;
    } rlle_batch_t;

    function automatic rlle_work_t f_put(rlle_work_t w, logic [ADDR_W-1:0] addr,
                                         logic [BYTE_W-1:0] data, logic done,
                                         logic [LEN_W-1:0] len);
        rlle_work_t r;
        r = w;
        if (r.cnt < RES_CNT_W'(MAX_RES))
        begin
            r.res[r.cnt].addr = done ? '0 : addr;
            r.res[r.cnt].data = done ? '0 : data;
            r.res[r.cnt].done = done;
            r.res[r.cnt].len  = done ? len : '0;
            r.res[r.cnt].last = 1'b0;
            r.cnt = r.cnt + RES_CNT_W'(1);
        end
        return r;
    endfunction

    function automatic rlle_work_t f_advance(rlle_work_t w);
        rlle_work_t r;
        r = w;
        if (r.st.nxt != ADDR_SAT)
        begin
            r.st.nxt = r.st.nxt + ADDR_W'(1);
        end
        return r;
    endfunction

    function automatic rlle_work_t f_put_next(rlle_work_t w, logic [BYTE_W-1:0] data);
        rlle_work_t r;
        r = f_put(w, w.st.nxt, data, 1'b0, '0);
        r = f_advance(r);
        return r;
    endfunction

    // reserve the count slot, then write the first literal
    function automatic rlle_work_t f_open_literal(rlle_work_t w, logic [BYTE_W-1:0] b);
        rlle_work_t r;
        r = w;
        r.st.slot = r.st.nxt;
        r = f_advance(r);
        r = f_put_next(r, b);
        r.st.run = LIT_ONE;
        return r;
    endfunction

    function automatic rlle_work_t f_first_item(rlle_work_t w, logic [BYTE_W-1:0] b0,
                                                logic [BYTE_W-1:0] b1, logic has2,
                                                logic [BYTE_W-1:0] b2);
        rlle_work_t r;
        r = w;
        if (b0 == b1)
        begin
            r.st.run = REPEAT_START;
        end
        else if (has2 && (b1 == b2))
        begin
            r = f_put_next(r, LIT_ONE);
            r = f_put_next(r, b0);
            r.st.run = RUN_NONE;
        end
        else
        begin
            r = f_open_literal(r, b0);
        end
        return r;
    endfunction

    function automatic rlle_work_t f_item(rlle_work_t w, logic [BYTE_W-1:0] prev,
                                          logic [BYTE_W-1:0] curr, logic has_next,
                                          logic [BYTE_W-1:0] nb);
        rlle_work_t        r;
        logic              lst;
        logic              rep;
        logic [BYTE_W-1:0] n;
        r   = w;
        lst = !has_next;
        rep = has_next && (curr == nb);
        n   = r.st.run;
        if (n == RUN_NONE)
        begin
            if (lst)
            begin
                r = f_put_next(r, LIT_ONE);
                r = f_put_next(r, curr);
            end
            else if (rep)
            begin
                r.st.run = REPEAT_START;
            end
            else
            begin
                r = f_open_literal(r, curr);
            end
        end
        else if (n[BYTE_W-1])
        begin
            if (prev == curr)
            begin
                n = n + BYTE_W'(1);
                r.st.run = n;
                if ((n == REPEAT_FULL) || lst)
                begin
                    r = f_put_next(r, n);
                    r = f_put_next(r, curr);
                    r.st.run = RUN_NONE;
                end
            end
            else
            begin
                r = f_put_next(r, n);
                r = f_put_next(r, prev);
                if (!rep)
                begin
                    r = f_open_literal(r, curr);
                    if (lst)
                    begin
                        r = f_put(r, r.st.slot, LIT_ONE, 1'b0, '0);
                        r.st.run = RUN_NONE;
                    end
                end
                else
                begin
                    r.st.run = REPEAT_START;
                end
            end
        end
        else
        begin
            if (!rep)
            begin
                n = n + BYTE_W'(1);
                r.st.run = n;
                r = f_put_next(r, curr);
                if ((n == LITERAL_FULL) || lst)
                begin
                    // patch the count back into the reserved slot
                    r = f_put(r, r.st.slot, n, 1'b0, '0);
                    r.st.run = RUN_NONE;
                end
            end
            else
            begin
                r = f_put(r, r.st.slot, n, 1'b0, '0);
                r.st.run = REPEAT_START;
            end
        end
        return r;
    endfunction

    // whole effect of one input byte on the state, with its result list
    function automatic rlle_work_t f_step(rlle_state_t st, logic [BYTE_W-1:0] b,
                                          logic last);
        rlle_work_t w;
        w.st  = st;
        w.res = '0;
        w.cnt = '0;
        unique case (st.seen)
            SEEN_NONE:
            begin
                if (last)
                begin
                    w = f_item(w, '0, b, 1'b0, '0);
                end
                else
                begin
                    w.st.held = b;
                    w.st.seen = SEEN_ONE;
                end
            end
            SEEN_ONE:
            begin
                if (last)
                begin
                    w = f_first_item(w, st.held, b, 1'b0, '0);
                    w = f_item(w, st.held, b, 1'b0, '0);
                end
                else
                begin
                    w.st.before_held = st.held;
                    w.st.held        = b;
                    w.st.seen        = SEEN_TWO;
                    w.st.run         = START_PENDING;
                end
            end
            default:
            begin
                if (st.run == START_PENDING)
                begin
                    w = f_first_item(w, st.before_held, st.held, 1'b1, b);
                end
                w = f_item(w, st.before_held, st.held, 1'b1, b);
                w.st.before_held = st.held;
                w.st.held        = b;
                if (last)
                begin
                    w = f_item(w, st.held, b, 1'b0, '0);
                end
            end
        endcase
        if (last)
        begin
            w = f_put(w, '0, '0, 1'b1, w.st.nxt);
            w.st = '0;
        end
        if (w.cnt != '0)
        begin
            w.res[w.cnt - RES_CNT_W'(1)].last = 1'b1;
        end
        return w;
    endfunction

endpackage

// ===== rtl/core/rlle_cfg.sv =====
// ----------------------------------------------------------------------------
// rlle_cfg
// APB register file: holds the output buffer capacity.
// ----------------------------------------------------------------------------
module rlle_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rlle_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rlle_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rlle_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [rlle_pkg::ADDR_W-1:0]     out_capacity
);
    import rlle_pkg::*;

    logic [ADDR_W-1:0] cap_reg;
    logic [ADDR_W-1:0] cap_next;
    logic              hit;

    // register 0 occupies the first word; low byte-lane bits are ignored
    assign hit    = (paddr[APB_ADDR_W-1] == 1'b0);
    assign pready = 1'b1;

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            cap_next = pwdata[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign prdata       = hit ? APB_DATA_W'(cap_reg) : '0;
    assign out_capacity = cap_reg;

endmodule

// ===== rtl/core/rlle_enc.sv =====
// ----------------------------------------------------------------------------
// rlle_enc
// Input register, stream state and the single-pass encode of one byte.
// ----------------------------------------------------------------------------
module rlle_enc
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rlle_pkg::BYTE_W-1:0]   in_byte,
    input  logic                          in_last,
    input  logic                          bank_free,
    output rlle_pkg::rlle_batch_t         batch
);
    import rlle_pkg::*;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [BYTE_W-1:0] in_byte_next;
    logic              in_last_reg;
    logic              in_last_next;
    rlle_state_t       state_reg;
    rlle_state_t       state_next;
    rlle_work_t        work;
    logic              consume;

    assign work = f_step(state_reg, in_byte_reg, in_last_reg);

    // an item with no results needs no room in the bank
    assign consume  = in_valid_reg && ((work.cnt == '0) || bank_free);
    assign in_ready = !in_valid_reg || consume;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_last_next  = in_last_reg;
        state_next    = state_reg;
        if (consume)
        begin
            state_next    = work.st;
            in_valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = in_byte;
            in_last_next  = in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
    end

    assign batch.valid = consume && (work.cnt != '0);
    assign batch.cnt   = work.cnt;
    assign batch.res   = work.res;

endmodule

// ===== rtl/core/rlle_out.sv =====
// ----------------------------------------------------------------------------
// rlle_out
// Result bank: holds the writes of one byte and drains them one beat a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module rlle_out
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rlle_pkg::rlle_batch_t              batch,
    output logic                               bank_free,
    input  logic [rlle_pkg::ADDR_W-1:0]        out_capacity,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rlle_pkg::OUT_TDATA_W-1:0]   out_data,
    output logic                               out_last,
    output logic                               out_user
);
    import rlle_pkg::*;

    rlle_res_arr_t        bank_reg;
    rlle_res_arr_t        bank_next;
    logic [RES_CNT_W-1:0] cnt_reg;
    logic [RES_CNT_W-1:0] cnt_next;
    logic                 take;
    rlle_res_t            head;
    logic                 in_bounds;

    assign take      = (cnt_reg != '0) && out_ready;
    assign bank_free = (cnt_reg == '0) || ((cnt_reg == RES_CNT_W'(1)) && take);

    always_comb
    begin
        bank_next = bank_reg;
        cnt_next  = cnt_reg;
        if (batch.valid)
        begin
            bank_next = batch.res;
            cnt_next  = batch.cnt;
        end
        else if (take)
        begin
            // advance the queue toward the head
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                bank_next[i] = bank_reg[i + 1];
            end
            cnt_next = cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg <= bank_next;
    end

    assign head      = bank_reg[0];
    assign in_bounds = !head.done && (head.addr < out_capacity);

    assign out_valid = (cnt_reg != '0);
    assign out_data  = {OUT_PAD_W'(0), head.len, in_bounds, head.data, head.addr};
    assign out_last  = head.last;
    assign out_user  = head.done;

endmodule

// ===== rtl/core/run_length_literal_encoder.sv =====
// ----------------------------------------------------------------------------
// run_length_literal_encoder
// Byte-stream run-length encoder with literal runs, emitting buffer writes.
// ----------------------------------------------------------------------------
// Input stream: one raw byte per beat on s_axis_tdata, s_axis_tlast on the
// final byte of a stream. Output stream: one buffer write per beat
// (address, data, in-bounds flag); m_axis_tuser marks the closing beat that
// carries the encoded length, m_axis_tlast marks the last beat caused by
// one input byte. The APB port holds the buffer capacity (reset 65535).
// Each byte's writes pass through the input register, then the result
// bank. The encoder keeps one byte of lookahead, two at the start of a
// stream, so writes trail the input.
// Throughput: one input byte per cycle while each byte yields at most one
// write and the receiver is ready; a byte yielding k writes (up to six)
// holds the single output channel until the six-entry result bank has
// drained them, one beat per cycle while the receiver is ready.
// Reset clears the stream state and the bank; the next stream starts at
// address 0, as it does after every closing beat. When the receiver stalls,
// the bank holds, one more byte waits in the input register, and
// s_axis_tready then drops.
// ----------------------------------------------------------------------------
module run_length_literal_encoder
(
    input  logic                              clk,
    input  logic                              rst_n,
    // in_byte
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [rlle_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // write_addr[15:0], write_data[23:16], in_bounds[24], encoded_length[40:25]
    output logic [rlle_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast,
    // is_done
    output logic                              m_axis_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rlle_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rlle_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rlle_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import rlle_pkg::*;

    logic [ADDR_W-1:0] out_capacity;
    rlle_batch_t       batch;
    logic              bank_free;

    rlle_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .out_capacity (out_capacity)
    );

    rlle_enc u_enc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata[BYTE_W-1:0]),
        .in_last   (s_axis_tlast),
        .bank_free (bank_free),
        .batch     (batch)
    );

    rlle_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .batch        (batch),
        .bank_free    (bank_free),
        .out_capacity (out_capacity),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata),
        .out_last     (m_axis_tlast),
        .out_user     (m_axis_tuser)
    );

endmodule
